// ===== sv/rad_pkg.sv =====
package rad_pkg;

  localparam int AUTH_BYTES   = 16;
  localparam int HDR_BYTES    = 4 + AUTH_BYTES;
  localparam int HPOS_W       = $clog2(HDR_BYTES);
  localparam logic [7:0] MIN_ATTR_LEN = 8'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TYPE   = 2'd1,
    PH_LEN    = 2'd2,
    PH_VALUE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_CODE = 3'd0,
    K_ID   = 3'd1,
    K_LENB = 3'd2,
    K_AUTH = 3'd3,
    K_TYPE = 3'd4,
    K_ALEN = 3'd5,
    K_VAL  = 3'd6,
    K_DISC = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_OVERRUN = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] attr_type;
    logic [7:0] value_byte;
    logic [7:0] value_index;
    logic       attr_end;
    status_t    status;
    logic       packet_end;
  } result_t;

endpackage

// ===== sv/rad_in_reg.sv =====
module rad_in_reg import rad_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       s_valid,
  output logic [7:0] s_data,
  output logic       s_last,
  input  logic       s_take
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       last_r;

  // stage frees up in the same cycle its transaction moves on
  assign in_ready  = !valid_r || s_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      last_r <= in_last;
    end
  end

  assign s_valid = valid_r;
  assign s_data  = data_r;
  assign s_last  = last_r;

endmodule

// ===== sv/rad_core.sv =====
module rad_core import rad_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last,
  output result_t    res
);

  phase_t            phase_r, phase_nxt;
  logic [HPOS_W-1:0] hpos_r, hpos_nxt;
  logic [7:0]        remain_r, remain_nxt;
  logic [7:0]        ctype_r, ctype_nxt;
  logic [7:0]        vpos_r, vpos_nxt;
  logic              err_r, err_nxt;
  logic [HPOS_W:0]   hpos_inc;
  logic [7:0]        remain_dec;

  assign hpos_inc   = {1'b0, hpos_r} + {{HPOS_W{1'b0}}, 1'b1};
  assign remain_dec = remain_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    hpos_nxt       = hpos_r;
    remain_nxt     = remain_r;
    ctype_nxt      = ctype_r;
    vpos_nxt       = vpos_r;
    err_nxt        = err_r;
    res.kind       = K_DISC;
    res.attr_type  = 8'd0;
    res.value_byte = data_byte;
    res.value_index = 8'd0;
    res.attr_end   = 1'b0;
    res.status     = ST_OK;
    res.packet_end = last;

    if (err_r) begin
      res.kind = K_DISC;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hpos_r == HPOS_W'(0)) begin
            res.kind = K_CODE;
          end else if (hpos_r == HPOS_W'(1)) begin
            res.kind = K_ID;
          end else if (hpos_r < HPOS_W'(4)) begin
            res.kind = K_LENB;
          end else begin
            res.kind = K_AUTH;
          end
          if (hpos_inc >= (HPOS_W+1)'(HDR_BYTES)) begin
            phase_nxt = PH_TYPE;
            hpos_nxt  = '0;
          end else begin
            hpos_nxt = hpos_inc[HPOS_W-1:0];
            if (last) res.status = ST_SHORT;
          end
        end
        PH_TYPE: begin
          res.kind      = K_TYPE;
          res.attr_type = data_byte;
          ctype_nxt     = data_byte;
          phase_nxt     = PH_LEN;
        end
        PH_LEN: begin
          res.kind      = K_ALEN;
          res.attr_type = ctype_r;
          if (data_byte < MIN_ATTR_LEN) begin
            res.status = ST_BAD_LEN;
            err_nxt    = 1'b1;
          end else if (data_byte == MIN_ATTR_LEN) begin
            res.attr_end = 1'b1;
            phase_nxt    = PH_TYPE;
          end else begin
            remain_nxt = data_byte - MIN_ATTR_LEN;
            vpos_nxt   = 8'd0;
            phase_nxt  = PH_VALUE;
            if (last) res.status = ST_OVERRUN;
          end
        end
        PH_VALUE: begin
          res.kind        = K_VAL;
          res.attr_type   = ctype_r;
          res.value_index = vpos_r;
          vpos_nxt        = vpos_r + 8'd1;
          remain_nxt      = remain_dec;
          if (remain_dec == 8'd0) begin
            res.attr_end = 1'b1;
            phase_nxt    = PH_TYPE;
          end else if (last) begin
            res.status = ST_OVERRUN;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  // last byte of a packet puts everything back to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last)) begin
      phase_r  <= PH_HEADER;
      hpos_r   <= '0;
      remain_r <= 8'd0;
      ctype_r  <= 8'd0;
      vpos_r   <= 8'd0;
      err_r    <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      hpos_r   <= hpos_nxt;
      remain_r <= remain_nxt;
      ctype_r  <= ctype_nxt;
      vpos_r   <= vpos_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ===== sv/rad_out_reg.sv =====
module rad_out_reg import rad_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    res,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_attr_type,
  output logic [7:0] out_value_byte,
  output logic [7:0] out_value_index,
  output logic       out_attr_end,
  output logic [1:0] out_status,
  output logic       out_packet_end
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = res_r.kind;
  assign out_attr_type   = res_r.attr_type;
  assign out_value_byte  = res_r.value_byte;
  assign out_value_index = res_r.value_index;
  assign out_attr_end    = res_r.attr_end;
  assign out_status      = res_r.status;
  assign out_packet_end  = res_r.packet_end;

endmodule

// ===== sv/radius_attribute_deframer.sv =====
// Path: input transaction -> input register -> parser logic -> result register.
// Throughput: one byte per cycle while out_ready keeps the result register free; the
// per-byte state update is a single pass of logic between the two registers.
// Reset: synchronous active-low rst_n empties both stages and puts the parser in the
// header phase; the parser also returns to the header phase after each last byte.
module radius_attribute_deframer import rad_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_attr_type,
  output logic [7:0] out_value_byte,
  output logic [7:0] out_value_index,
  output logic       out_attr_end,
  output logic [1:0] out_status,
  output logic       out_packet_end
);

  logic       s_valid;
  logic [7:0] s_data;
  logic       s_last;
  logic       s_take;
  logic       can_load;
  result_t    res;

  assign s_take = s_valid && can_load;

  rad_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .s_valid      (s_valid),
    .s_data       (s_data),
    .s_last       (s_last),
    .s_take       (s_take)
  );

  rad_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s_take),
    .data_byte (s_data),
    .last      (s_last),
    .res       (res)
  );

  rad_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (s_take),
    .res             (res),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_attr_type   (out_attr_type),
    .out_value_byte  (out_value_byte),
    .out_value_index (out_value_index),
    .out_attr_end    (out_attr_end),
    .out_status      (out_status),
    .out_packet_end  (out_packet_end)
  );

endmodule
